/* hw/rtl/pfra_pkg.sv */
// Package for the page frame refcount allocator.
// Holds the action codes, field widths and the result struct shared by the allocator and its output register.
// No dependencies.
package pfra_pkg;

    localparam int START_W    = 12;
    localparam int CNT_W      = 13;
    localparam int LIMIT_W    = 13;
    localparam int PAGE_W     = 14;
    localparam int INDEX_W    = 12;
    localparam int FRAME_W    = 24;
    localparam int PAGE_SHIFT = 12;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [1:0] {
        ACT_MARK_OCC  = 2'd0,
        ACT_MARK_AVL  = 2'd1,
        ACT_FIND_FREE = 2'd2,
        ACT_ALLOC_RUN = 2'd3
    } action_t;

    typedef struct packed {
        logic                 status;
        logic [INDEX_W-1:0]   page_index;
        logic [FRAME_W-1:0]   frame_address;
    } result_t;

endpackage

/* hw/rtl/pfra_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module pfra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/pfra_out_reg.sv */
// Result output register for the page frame refcount allocator.
// Holds one result beat until the master side takes it. Depends on pfra_pkg.
module pfra_out_reg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               push,
    input  pfra_pkg::result_t                  res,
    output logic                               free,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pfra_pkg::M_TDATA_W-1:0]     m_tdata,  // page_index, frame_address
    output logic                               m_tuser   // status
);

    logic              valid_reg;
    pfra_pkg::result_t data_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.status;
    assign m_tdata  = {{(pfra_pkg::M_TDATA_W - pfra_pkg::FRAME_W - pfra_pkg::INDEX_W){1'b0}},
                       data_reg.frame_address, data_reg.page_index};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
        if (push) begin
            data_reg <= res;
        end
    end

endmodule

/* hw/rtl/page_frame_refcount_allocator.sv */
// Page frame refcount allocator: per-page count table in one RAM, next-fit cursor.
// Mark walks the range; find-free scans pages below min(page_limit,PAGES) from the cursor,
// then from page 1; contiguous alloc scans from page 1 for a free run, then marks it.
// One item at a time: the next beat can be taken in the cycle after the result is pushed out.
// Reset: clearing pass writes 1 to all PAGES entries (s_tready low throughout);
// cursor resets to 1, page_limit to 4096. Config writes are taken at any time.
module page_frame_refcount_allocator #(
    parameter int PAGES      = 4096,
    parameter int COUNT_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [pfra_pkg::LIMIT_W-1:0]       cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pfra_pkg::S_TDATA_W-1:0]     s_tdata,  // start_page, num_pages
    input  logic [1:0]                         s_tuser,  // action
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pfra_pkg::M_TDATA_W-1:0]     m_tdata,  // page_index, frame_address
    output logic                               m_tuser   // status
);

    localparam int ADDR_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PAGES - 1);
    localparam logic [pfra_pkg::LIMIT_W-1:0] PAGES_LIM = pfra_pkg::LIMIT_W'(PAGES);
    localparam int PW = pfra_pkg::PAGE_W;
    localparam int LW = pfra_pkg::LIMIT_W;
    localparam int CW = pfra_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK,
        ST_FIND,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     clr_reg, clr_next;
    logic [LW-1:0]         limit_reg;
    logic [LW-1:0]         cursor_reg, cursor_next;
    pfra_pkg::action_t     op_reg, op_next;
    logic [LW-1:0]         base_reg, base_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic [ADDR_W-1:0]     pend_addr_reg, pend_addr_next;
    logic [LW-1:0]         pos_reg, pos_next;
    logic [LW-1:0]         p1_reg, p1_next;
    logic [LW-1:0]         upto_reg, upto_next;
    logic                  pass2_reg, pass2_next;
    logic [LW-1:0]         old_reg, old_next;
    pfra_pkg::result_t     res_reg, res_next;

    logic [LW-1:0]         lim;
    logic [LW-1:0]         upto2;
    logic [LW-1:0]         nxt;
    logic [LW-1:0]         p1n;
    logic [LW-1:0]         run_len;
    logic [PW-1:0]         mark_page;
    logic                  mark_inr;
    logic [PW+ADDR_W-1:0]  mark_wide;
    logic [PW-1:0]         rd_page;
    logic [PW+ADDR_W-1:0]  rd_wide;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [COUNT_BITS-1:0] rd_data;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic [COUNT_BITS-1:0] cnt_up;
    logic [COUNT_BITS-1:0] cnt_dn;
    logic                  push;
    logic                  out_free;
    logic [pfra_pkg::START_W-1:0] in_start;
    logic [CW-1:0]         in_count;

    assign in_start = s_tdata[pfra_pkg::START_W-1:0];
    assign in_count = s_tdata[pfra_pkg::START_W +: CW];
    assign s_tready = (state_reg == ST_IDLE);

    assign lim   = ({19'b0, limit_reg} < PAGES) ? limit_reg : PAGES_LIM;
    assign upto2 = (old_reg < lim) ? old_reg : lim;
    assign nxt   = pos_reg + LW'(1);
    assign p1n   = (rd_data == '0) ? p1_reg : nxt;
    assign run_len = nxt - p1n;

    assign mark_page = {1'b0, base_reg} + {1'b0, idx_reg};
    assign mark_inr  = ({18'b0, mark_page} < PAGES);
    assign mark_wide = {{ADDR_W{1'b0}}, mark_page};
    assign rd_wide   = {{ADDR_W{1'b0}}, rd_page};
    assign rd_addr   = rd_wide[ADDR_W-1:0];

    assign cnt_up = (rd_data == '1) ? rd_data : rd_data + COUNT_BITS'(1);
    assign cnt_dn = (rd_data == '0) ? rd_data : rd_data - COUNT_BITS'(1);

    function automatic pfra_pkg::result_t make_res(input logic st, input logic [LW-1:0] pg);
        pfra_pkg::result_t r;
        r.status        = st;
        r.page_index    = pg[pfra_pkg::INDEX_W-1:0];
        r.frame_address = {pg[pfra_pkg::INDEX_W-1:0], {pfra_pkg::PAGE_SHIFT{1'b0}}};
        return r;
    endfunction

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cursor_next    = cursor_reg;
        op_next        = op_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        pos_next       = pos_reg;
        p1_next        = p1_reg;
        upto_next      = upto_reg;
        pass2_next     = pass2_reg;
        old_next       = old_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        rd_page        = '0;
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = (op_reg == pfra_pkg::ACT_MARK_AVL) ? cnt_dn : cnt_up;
        push           = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = COUNT_BITS'(1);
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next  = pfra_pkg::action_t'(s_tuser);
                    cnt_next = in_count;
                    case (pfra_pkg::action_t'(s_tuser)) inside
                        pfra_pkg::ACT_MARK_OCC, pfra_pkg::ACT_MARK_AVL: begin
                            base_next  = {1'b0, in_start};
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            res_next   = make_res(1'b0, '0);
                            state_next = ST_MARK;
                        end
                        pfra_pkg::ACT_FIND_FREE: begin
                            old_next = cursor_reg;
                            if (cursor_reg < lim) begin
                                pos_next   = cursor_reg;
                                upto_next  = lim;
                                pass2_next = 1'b0;
                                rd_en      = 1'b1;
                                rd_page    = {1'b0, cursor_reg};
                                state_next = ST_FIND;
                            end else begin
                                cursor_next = LW'(1);
                                if (LW'(1) < ((cursor_reg < lim) ? cursor_reg : lim)) begin
                                    pos_next   = LW'(1);
                                    upto_next  = (cursor_reg < lim) ? cursor_reg : lim;
                                    pass2_next = 1'b1;
                                    rd_en      = 1'b1;
                                    rd_page    = PW'(1);
                                    state_next = ST_FIND;
                                end else begin
                                    res_next   = make_res(1'b1, '0);
                                    state_next = ST_DONE;
                                end
                            end
                        end
                        default: begin
                            if (in_count == '0) begin
                                res_next   = make_res(1'b0, LW'(1));
                                state_next = ST_DONE;
                            end else if (lim > LW'(1)) begin
                                pos_next   = LW'(1);
                                p1_next    = LW'(1);
                                rd_en      = 1'b1;
                                rd_page    = PW'(1);
                                state_next = ST_RUN;
                            end else begin
                                res_next   = make_res(1'b1, '0);
                                state_next = ST_DONE;
                            end
                        end
                    endcase
                end
            end
            ST_FIND: begin
                if (rd_data == '0) begin
                    cursor_next = pos_reg;
                    res_next    = make_res(1'b0, pos_reg);
                    state_next  = ST_DONE;
                end else if (nxt < upto_reg) begin
                    pos_next = nxt;
                    rd_en    = 1'b1;
                    rd_page  = {1'b0, nxt};
                end else if (!pass2_reg && (LW'(1) < upto2)) begin
                    cursor_next = LW'(1);
                    pos_next    = LW'(1);
                    upto_next   = upto2;
                    pass2_next  = 1'b1;
                    rd_en       = 1'b1;
                    rd_page     = PW'(1);
                end else begin
                    cursor_next = LW'(1);
                    res_next    = make_res(1'b1, '0);
                    state_next  = ST_DONE;
                end
            end
            ST_RUN: begin
                if ((nxt < lim) && (run_len < cnt_reg)) begin
                    pos_next = nxt;
                    p1_next  = p1n;
                    rd_en    = 1'b1;
                    rd_page  = {1'b0, nxt};
                end else if ((nxt >= lim) && (run_len < cnt_reg)) begin
                    res_next   = make_res(1'b1, '0);
                    state_next = ST_DONE;
                end else begin
                    base_next  = p1n;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    res_next   = make_res(1'b0, p1n);
                    state_next = ST_MARK;
                end
            end
            ST_MARK: begin
                if (idx_reg < cnt_reg) begin
                    rd_en          = mark_inr;
                    rd_page        = mark_page;
                    pend_next      = mark_inr;
                    pend_addr_next = mark_wide[ADDR_W-1:0];
                    idx_next       = idx_reg + CW'(1);
                end else begin
                    pend_next = 1'b0;
                end
                wr_en = pend_reg;
                if (!(idx_reg < cnt_reg) && !pend_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            cursor_reg <= LW'(1);
            limit_reg  <= LW'(4096);
            pend_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            cursor_reg <= cursor_next;
            pend_reg   <= pend_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
        end
        op_reg        <= op_next;
        base_reg      <= base_next;
        cnt_reg       <= cnt_next;
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        pos_reg       <= pos_next;
        p1_reg        <= p1_next;
        upto_reg      <= upto_next;
        pass2_reg     <= pass2_next;
        old_reg       <= old_next;
        res_reg       <= res_next;
    end

    pfra_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (PAGES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pfra_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .res      (res_reg),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input accepted during clearing pass");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start work");

    a_cursor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cursor_reg != '0))
        else $error("search cursor reached page zero");

    a_push_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> out_free)
        else $error("result pushed into a full output register");

    a_write_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> ((state_reg == ST_CLEAR) || (state_reg == ST_MARK)))
        else $error("table write outside clear or mark phase");

endmodule
